// ===== hdl/ptbu_pkg.sv =====
// Package: shared types and constants for the packed ten-bit line unpacker.
package ptbu_pkg;

    // Configuration register width and indexes
    localparam int CFG_W = 11;

    typedef enum logic [0:0] {
        CFG_LINE_WIDTH   = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd512;
    localparam logic [CFG_W-1:0] MIN_LINE_WIDTH     = 11'd4;
    localparam logic [CFG_W-1:0] MIN_FRAME_HEIGHT   = 11'd1;

    // Bit store geometry
    localparam int STORE_W = 18;
    localparam int HELD_W  = 5;
    localparam int VALUE_W = 10;
    localparam int BYTE_W  = 8;

    localparam logic [HELD_W-1:0] BYTE_BITS  = 5'd8;
    localparam logic [HELD_W-1:0] VALUE_BITS = 5'd10;

    // Number of sync values that open each line
    localparam int SYNC_VALUES = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       line_end;
        logic       frame_end;
    } out_word_t;

endpackage

// ===== hdl/packed_ten_bit_line_unpacker.sv =====
// Top level: unpacks a stream of bytes holding packed 10-bit values into 8-bit pixels.
// A pixel is formed from the input register word, then held in the result register.
// Throughput: one byte per cycle when not stalled; bit store update is a single pass.
// An input register and a result register part the two sides of the block.
// Reset: clears the bit store and counters, loads line_width 640 and frame_height 512,
// and waits for a byte marked first_byte before any pixel is produced.
module packed_ten_bit_line_unpacker
    import ptbu_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Configuration port
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    // Byte channel
    input  logic             byte_valid,
    output logic             byte_stall,
    input  in_word_t         byte_data,
    // Pixel channel
    output logic             pixel_valid,
    input  logic             pixel_stall,
    output out_word_t        pixel_data
);

    localparam int VIL_W = $clog2(MAX_WIDTH + SYNC_VALUES);
    localparam int LC_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MW_B  = $clog2(MAX_WIDTH + 1);
    localparam int MH_B  = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP_W = ((VIL_W > CFG_W) ? VIL_W : CFG_W) + ((MW_B > CFG_W) ? MW_B : 0) + 2;
    localparam int HCMP_W = ((LC_W > CFG_W) ? LC_W : CFG_W) + ((MH_B > CFG_W) ? MH_B : 0) + 2;
    localparam logic [WCMP_W-1:0] MAX_W_C = WCMP_W'(MAX_WIDTH);
    localparam logic [HCMP_W-1:0] MAX_H_C = HCMP_W'(MAX_HEIGHT);

    // Configuration registers
    logic [CFG_W-1:0] line_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    // Input register
    logic     s1_valid_reg;
    in_word_t s1_word_reg;

    // Unpacker state
    logic [STORE_W-1:0] bit_store_reg,     bit_store_next;
    logic [HELD_W-1:0]  bits_held_reg,     bits_held_next;
    logic [VIL_W-1:0]   value_in_line_reg, value_in_line_next;
    logic [LC_W-1:0]    line_count_reg,    line_count_next;
    logic               frame_over_reg,    frame_over_next;

    // Result register
    logic      out_valid_reg;
    out_word_t out_word_reg;

    logic      out_free;
    logic      s1_advance;
    logic      result_hit;
    out_word_t result_word;

    // Working values of the single pass
    logic [STORE_W-1:0] store0, store1, store_mask;
    logic [HELD_W-1:0]  held0, held1, held2, shift_amt;
    logic [VIL_W-1:0]   vil0;
    logic [LC_W-1:0]    lc0;
    logic               over0;
    logic [STORE_W-1:0] shifted;
    logic [VALUE_W-1:0] value;
    logic [WCMP_W-1:0]  width_raw, width_c;
    logic [HCMP_W-1:0]  height_raw, height_c;
    logic               is_line_end;

    // Handshake: result register takes a new word when empty or drained
    assign out_free    = !out_valid_reg || !pixel_stall;
    assign s1_advance  = s1_valid_reg && out_free;
    assign byte_stall  = s1_valid_reg && !out_free;
    assign pixel_valid = out_valid_reg;
    assign pixel_data  = out_word_reg;

    // Clamp configuration to the supported range
    assign width_raw  = WCMP_W'(line_width_reg);
    assign height_raw = HCMP_W'(frame_height_reg);

    always_comb
    begin
        if (width_raw < WCMP_W'(MIN_LINE_WIDTH))
            width_c = WCMP_W'(MIN_LINE_WIDTH);
        else if (width_raw > MAX_W_C)
            width_c = MAX_W_C;
        else
            width_c = width_raw;

        if (height_raw < HCMP_W'(MIN_FRAME_HEIGHT))
            height_c = HCMP_W'(MIN_FRAME_HEIGHT);
        else if (height_raw > MAX_H_C)
            height_c = MAX_H_C;
        else
            height_c = height_raw;
    end

    // Unpack one byte: shift in, extract a value, count position
    always_comb
    begin
        // Restart position on a first byte
        if (s1_word_reg.first_byte)
        begin
            store0 = '0;
            held0  = '0;
            vil0   = '0;
            lc0    = '0;
            over0  = 1'b0;
        end
        else
        begin
            store0 = bit_store_reg;
            held0  = bits_held_reg;
            vil0   = value_in_line_reg;
            lc0    = line_count_reg;
            over0  = frame_over_reg;
        end

        store1     = {store0[STORE_W-BYTE_W-1:0], s1_word_reg.data_byte};
        held1      = held0 + BYTE_BITS;
        held2      = held1 - VALUE_BITS;
        shift_amt  = held2;
        shifted    = store1 >> shift_amt;
        value      = shifted[VALUE_W-1:0];
        store_mask = ~({STORE_W{1'b1}} << held2);

        bit_store_next     = store0;
        bits_held_next     = held0;
        value_in_line_next = vil0;
        line_count_next    = lc0;
        frame_over_next    = over0;
        result_hit         = 1'b0;
        is_line_end        = 1'b0;
        result_word        = '{pixel: value[VALUE_W-1:2], line_end: 1'b0, frame_end: 1'b0};

        if (!over0)
        begin
            if (held1 < VALUE_BITS)
            begin
                bit_store_next = store1;
                bits_held_next = held1;
            end
            else
            begin
                bit_store_next = store1 & store_mask;
                bits_held_next = held2;
                if (vil0 < VIL_W'(SYNC_VALUES))
                begin
                    // Drop a sync value
                    value_in_line_next = vil0 + VIL_W'(1);
                end
                else
                begin
                    result_hit  = 1'b1;
                    is_line_end = WCMP_W'(vil0) >= width_c + WCMP_W'(SYNC_VALUES - 1);
                    result_word.line_end = is_line_end;
                    if (is_line_end)
                    begin
                        value_in_line_next = '0;
                        if (HCMP_W'(lc0) + HCMP_W'(1) >= height_c)
                        begin
                            // Close the frame and drop leftover bits
                            result_word.frame_end = 1'b1;
                            frame_over_next       = 1'b1;
                            bit_store_next        = '0;
                            bits_held_next        = '0;
                            line_count_next       = '0;
                        end
                        else
                        begin
                            line_count_next = lc0 + LC_W'(1);
                        end
                    end
                    else
                    begin
                        value_in_line_next = vil0 + VIL_W'(1);
                    end
                end
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINE_WIDTH:   line_width_reg   <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!byte_stall)
            s1_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            s1_word_reg <= byte_data;
    end

    // Unpacker state: advance once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_store_reg     <= '0;
            bits_held_reg     <= '0;
            value_in_line_reg <= '0;
            line_count_reg    <= '0;
            frame_over_reg    <= 1'b1;
        end
        else if (s1_advance)
        begin
            bit_store_reg     <= bit_store_next;
            bits_held_reg     <= bits_held_next;
            value_in_line_reg <= value_in_line_next;
            line_count_reg    <= line_count_next;
            frame_over_reg    <= frame_over_next;
        end
    end

    // Result register: load a pixel, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_advance && result_hit;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && result_hit)
            out_word_reg <= result_word;
    end

    // Checks on the unpacker logic
    a_frame_end_on_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (!pixel_data.frame_end || pixel_data.line_end))
        else $error("frame_end without line_end");

    a_held_below_value: assert property (@(posedge clk) disable iff (!rst_n)
        bits_held_reg < VALUE_BITS)
        else $error("bit store holds a full value");

    a_store_within_held: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_store_reg >> bits_held_reg) == '0)
        else $error("bit store has bits above the held count");

    a_idle_position_clear: assert property (@(posedge clk) disable iff (!rst_n)
        frame_over_reg |-> (bits_held_reg == '0 && value_in_line_reg == '0
                            && line_count_reg == '0))
        else $error("position not cleared while waiting for a first byte");

endmodule
